/* hdl/hspd_pkg.sv */
// Shared types and constants for the humidity sensor pulse decoder.
// No dependencies; every other file of the block imports this package.
package hspd_pkg;

    localparam int DATA_BITS = 40;
    localparam int FRAME_LEN = 2 + 2 * DATA_BITS;
    localparam int IDX_W = 7;
    localparam int US_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [IDX_W-1:0] HANDSHAKE_LEN = IDX_W'(2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    localparam logic [US_W-1:0] READY_MAX_RESET = US_W'(100);
    localparam logic [US_W-1:0] BIT_START_MAX_RESET = US_W'(75);
    localparam logic [US_W-1:0] BIT_MAX_RESET = US_W'(100);
    localparam logic [US_W-1:0] ONE_THRESHOLD_RESET = US_W'(40);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_READY_MAX     = 2'd0,
        REG_BIT_START_MAX = 2'd1,
        REG_BIT_MAX       = 2'd2,
        REG_ONE_THRESHOLD = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_START    = 2'd0,
        OP_INTERVAL = 2'd1,
        OP_TIMEOUT  = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_COMPLETE    = 2'd0,
        ST_NO_RESPONSE = 2'd1,
        ST_OVERRUN     = 2'd2
    } status_t;

    typedef struct packed {
        logic [US_W-1:0] ready_max;
        logic [US_W-1:0] bit_start_max;
        logic [US_W-1:0] bit_max;
        logic [US_W-1:0] one_threshold;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] transition_index;
        logic [US_W-1:0]  overrun_us;
        logic [US_W-1:0]  humidity_tenths;
        logic [US_W-1:0]  temperature_tenths;
        logic             sum_ok;
    } result_t;

endpackage

/* hdl/humidity_sensor_pulse_decoder.sv */
// Top level of the humidity sensor pulse decoder.
// Depends on hspd_pkg, hspd_cfg_regs, hspd_decoder and hspd_out_reg.
//
// Usage: each input request carries an operation (start, interval, timeout) and an
// interval in microseconds, moved on the in_valid/in_ready handshake. A start request
// opens a frame; the following intervals are checked against the configured limits
// and the data bits are shifted in. A frame ends with one result request on the
// out_valid/out_ready handshake: complete, no response, or interval over its limit.
// Requests that end nothing give no result.
// An accepted request is loaded into the input register; the decode logic then loads
// its result into the result register behind out_valid, once that register is free.
// One request is accepted every cycle while the receiver does not stall, the rate being
// set by the combinational compare-and-shift path between the two registers.
// When the receiver stalls, the result register holds its request and the input
// register fills; in_ready then falls until out_ready returns. Reset restores
// the default limits and leaves no frame open. The limits are to be written through
// cfg_we, cfg_index and cfg_wdata only while no frame is being processed; not enforced.
module humidity_sensor_pulse_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hspd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hspd_pkg::US_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic [hspd_pkg::US_W-1:0]           interval_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [hspd_pkg::IDX_W-1:0]          transition_index,
    output logic [hspd_pkg::US_W-1:0]           overrun_us,
    output logic [hspd_pkg::US_W-1:0]           humidity_tenths,
    output logic [hspd_pkg::US_W-1:0]           temperature_tenths,
    output logic                                sum_ok
);
    import hspd_pkg::*;

    cfg_t    cfg;
    logic    advance;
    logic    res_valid;
    result_t res;
    result_t out_res;

    hspd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hspd_decoder u_decoder (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_operation   (operation),
        .in_interval_us (interval_us),
        .advance        (advance),
        .res_valid      (res_valid),
        .res            (res)
    );

    hspd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status = out_res.status;
    assign transition_index = out_res.transition_index;
    assign overrun_us = out_res.overrun_us;
    assign humidity_tenths = out_res.humidity_tenths;
    assign temperature_tenths = out_res.temperature_tenths;
    assign sum_ok = out_res.sum_ok;

endmodule

/* hdl/hspd_cfg_regs.sv */
// Configuration register bank of the pulse decoder limits.
// Depends on hspd_pkg for the register indexes and the cfg_t bundle.
module hspd_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hspd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hspd_pkg::US_W-1:0]           cfg_wdata,
    output hspd_pkg::cfg_t                      cfg
);
    import hspd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_READY_MAX:     cfg_next.ready_max = cfg_wdata;
                REG_BIT_START_MAX: cfg_next.bit_start_max = cfg_wdata;
                REG_BIT_MAX:       cfg_next.bit_max = cfg_wdata;
                REG_ONE_THRESHOLD: cfg_next.one_threshold = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ready_max <= READY_MAX_RESET;
            cfg_reg.bit_start_max <= BIT_START_MAX_RESET;
            cfg_reg.bit_max <= BIT_MAX_RESET;
            cfg_reg.one_threshold <= ONE_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/hspd_decoder.sv */
// Input register and frame state of the pulse decoder; forms the result of each request that ends a frame.
// Depends on hspd_pkg for the operation codes, limits bundle and result type.
module hspd_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hspd_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_operation,
    input  logic [hspd_pkg::US_W-1:0]    in_interval_us,
    input  logic                         advance,
    output logic                         res_valid,
    output hspd_pkg::result_t            res
);
    import hspd_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    op_t                  op_reg;
    logic [US_W-1:0]      interval_reg;

    logic                 active_reg;
    logic                 active_next;
    logic [IDX_W-1:0]     count_reg;
    logic [IDX_W-1:0]     count_next;
    logic [DATA_BITS-1:0] bits_reg;
    logic [DATA_BITS-1:0] bits_next;

    logic                 process;
    logic                 in_accept;
    logic [US_W-1:0]      limit;
    logic                 value_slot;
    logic [DATA_BITS-1:0] shifted_bits;
    logic [7:0]           byte_sum;

    assign in_ready = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;
    assign process = s1_valid_reg && advance;
    assign s1_valid_next = in_accept || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            active_reg <= 1'b0;
            count_reg <= '0;
            bits_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            active_reg <= active_next;
            count_reg <= count_next;
            bits_reg <= bits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= op_t'(in_operation);
            interval_reg <= in_interval_us;
        end
    end

    always_comb
    begin
        value_slot = 1'b0;
        if (count_reg < HANDSHAKE_LEN)
        begin
            limit = cfg.ready_max;
        end
        else if (!count_reg[0])
        begin
            limit = cfg.bit_start_max;
        end
        else
        begin
            limit = cfg.bit_max;
            value_slot = 1'b1;
        end
    end

    assign shifted_bits = {bits_reg[DATA_BITS-2:0], interval_reg > cfg.one_threshold};
    assign byte_sum = shifted_bits[39:32] + shifted_bits[31:24]
                    + shifted_bits[23:16] + shifted_bits[15:8];

    always_comb
    begin
        active_next = active_reg;
        count_next = count_reg;
        bits_next = bits_reg;
        res_valid = 1'b0;
        res.status = ST_NO_RESPONSE;
        res.transition_index = count_reg;
        res.overrun_us = '0;
        res.humidity_tenths = '0;
        res.temperature_tenths = '0;
        res.sum_ok = 1'b0;
        if (process)
        begin
            case (op_reg)
                OP_START:
                begin
                    active_next = 1'b1;
                    count_next = '0;
                    bits_next = '0;
                end
                OP_INTERVAL:
                begin
                    if (active_reg)
                    begin
                        if (interval_reg == '0)
                        begin
                            active_next = 1'b0;
                            res_valid = 1'b1;
                        end
                        else if (interval_reg > limit)
                        begin
                            active_next = 1'b0;
                            res_valid = 1'b1;
                            res.status = ST_OVERRUN;
                            res.overrun_us = interval_reg - limit;
                        end
                        else
                        begin
                            if (value_slot)
                            begin
                                bits_next = shifted_bits;
                            end
                            count_next = count_reg + 1'b1;
                            if (count_reg >= LAST_IDX)
                            begin
                                active_next = 1'b0;
                                res_valid = 1'b1;
                                res.status = ST_COMPLETE;
                                res.humidity_tenths = bits_next[39:24];
                                res.temperature_tenths = bits_next[23:8];
                                res.sum_ok = (byte_sum == bits_next[7:0]);
                            end
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    if (active_reg)
                    begin
                        active_next = 1'b0;
                        res_valid = 1'b1;
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

endmodule

/* hdl/hspd_out_reg.sv */
// Result register of the pulse decoder, holding one result until it is taken.
// Depends on hspd_pkg for the result type.
module hspd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  hspd_pkg::result_t    res,
    output logic                 advance,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hspd_pkg::result_t    out_res
);
    import hspd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res = res_reg;

endmodule
